// ===== hw/rtl/lcg_key_xor_stream_cipher_unit_defines.svh =====
// assertion macros for the lcg key xor stream cipher unit
// expects clk and rst_n in the scope of the module that includes it
`ifndef LCG_KEY_XOR_STREAM_CIPHER_UNIT_DEFINES_SVH
`define LCG_KEY_XOR_STREAM_CIPHER_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define LCGXSC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define LCGXSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/lcgxsc_pkg.sv =====
// shared constants and tables for the lcg key xor stream cipher unit
// no dependencies
package lcgxsc_pkg;

    localparam logic [31:0] LCG_MUL = 32'd214013;
    localparam logic [31:0] LCG_INC = 32'd2531011;

    localparam int KEY_LENGTH_DEFAULT = 32;

    localparam logic [6:0] CHARSET_SIZE = 7'd61;

    // header position counter: counts bytes 0..2, then holds
    localparam logic [1:0] HDR_POS_LAST = 2'd2;
    localparam logic [1:0] HDR_POS_FULL = 2'd3;

    localparam logic [7:0] HDR_BYTE_0 = 8'd66;
    localparam logic [7:0] HDR_BYTE_1 = 8'd90;
    localparam logic [7:0] HDR_BYTE_2 = 8'd104;

    // key charset: a-z, then A-Z, then 1-9
    function automatic logic [7:0] key_char(input logic [5:0] idx);
        logic [7:0] res;
        res = 8'd0;
        priority if (idx < 6'd26)
            res = 8'd97 + {2'b00, idx};
        else if (idx < 6'd52)
            res = 8'd65 + {2'b00, idx - 6'd26};
        else if (idx < 6'd61)
            res = 8'd49 + {2'b00, idx - 6'd52};
        else
            res = 8'd0;
        return res;
    endfunction

    function automatic logic [7:0] hdr_byte(input logic [1:0] pos);
        logic [7:0] res;
        res = 8'd0;
        unique case (pos)
            2'd0:    res = HDR_BYTE_0;
            2'd1:    res = HDR_BYTE_1;
            2'd2:    res = HDR_BYTE_2;
            default: res = 8'd0;
        endcase
        return res;
    endfunction

endpackage

// ===== hw/rtl/lcgxsc_key_char.sv =====
// maps a 15-bit generator output to a key character (value mod 61, then charset)
// depends on lcgxsc_pkg
module lcgxsc_key_char
    import lcgxsc_pkg::*;
(
    input  logic [14:0] rand_val,
    output logic [7:0]  key_out
);

    logic [10:0] fold1;
    logic [7:0]  fold2;
    logic [6:0]  fold3;
    logic [5:0]  char_idx;

    // 64 = 3 mod 61, so fold the upper bits down by 3x until under 2*61
    always_comb
    begin
        fold1 = ({2'b00, rand_val[14:6]} * 11'd3) + {5'd0, rand_val[5:0]};
        fold2 = ({3'b000, fold1[10:6]} * 8'd3) + {2'b00, fold1[5:0]};
        fold3 = ({5'd0, fold2[7:6]} * 7'd3) + {1'b0, fold2[5:0]};
        if (fold3 >= CHARSET_SIZE)
            char_idx = 6'(fold3 - CHARSET_SIZE);
        else
            char_idx = fold3[5:0];
        key_out = key_char(char_idx);
    end

endmodule

// ===== hw/rtl/lcg_key_xor_stream_cipher_unit.sv =====
// top level of the lcg key xor stream cipher: key generation, key store,
// header check and output register; depends on lcgxsc_pkg, lcgxsc_key_char
// and the assertion macro header
//
//  channel   direction  signals                                     handshake
//  in        input      data_byte, start_of_message                 in_valid / in_ready
//  out       output     out_byte, header_done, header_match         out_valid / out_ready
//  seed      input      seed_wdata                                  seed_we (no wait)
//
// one byte per cycle unless stalled; a transferred byte lands in the output register
// the generator step multiplier feeds only its own register, the seed is pre-stepped
// on write, so the per-byte path is a mux, a mod-61 fold, a table and an xor
// in_ready drops only while the output register is full and out_ready is low
// reset returns the block to a fresh message with seed 0; the key store is not cleared
`include "lcg_key_xor_stream_cipher_unit_defines.svh"

module lcg_key_xor_stream_cipher_unit
    import lcgxsc_pkg::*;
#(
    parameter int KEY_LENGTH = KEY_LENGTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        seed_we,
    input  logic [31:0] seed_wdata,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        start_of_message,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        header_done,
    output logic        header_match
);

    localparam int PosW = (KEY_LENGTH > 1) ? $clog2(KEY_LENGTH) : 1;
    localparam logic [PosW-1:0] PosLast = PosW'(KEY_LENGTH - 1);

    // generator values are kept already stepped: the state this byte would use
    logic [31:0]      seed_step_reg;
    logic [31:0]      gen_step_reg;
    logic [31:0]      gen_step_next;
    logic [PosW-1:0]  pos_reg;
    logic [PosW-1:0]  pos_next;
    logic             first_pass_reg;
    logic             first_pass_next;
    logic [1:0]       hdr_pos_reg;
    logic [1:0]       hdr_pos_next;
    logic             hdr_ok_reg;
    logic             hdr_ok_next;

    logic [7:0]       key_mem [KEY_LENGTH];
    logic [7:0]       key_rd_reg;

    logic             out_valid_reg;
    logic [7:0]       out_byte_reg;
    logic             header_done_reg;
    logic             header_match_reg;

    logic             in_fire;
    logic [31:0]      state_cur;
    logic [PosW-1:0]  pos_cur;
    logic             first_pass_cur;
    logic [1:0]       hdr_pos_cur;
    logic             hdr_ok_cur;
    logic [7:0]       gen_char;
    logic [7:0]       key_cur;
    logic [7:0]       result;
    logic             pos_wrap;
    logic             hdr_active;
    logic             hdr_last;
    logic             match_cur;
    logic             key_wr_en;
    logic [PosW-1:0]  rd_addr;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    lcgxsc_key_char u_key_char
    (
        .rand_val (state_cur[30:16]),
        .key_out  (gen_char)
    );

    always_comb
    begin
        // a start flag restarts the message before this byte
        state_cur      = start_of_message ? seed_step_reg : gen_step_reg;
        pos_cur        = start_of_message ? '0 : pos_reg;
        first_pass_cur = start_of_message || first_pass_reg;
        hdr_pos_cur    = start_of_message ? 2'd0 : hdr_pos_reg;
        hdr_ok_cur     = start_of_message || hdr_ok_reg;

        key_cur = first_pass_cur ? gen_char : key_rd_reg;
        result  = data_byte ^ key_cur;

        pos_wrap        = (pos_cur == PosLast);
        pos_next        = pos_wrap ? '0 : pos_cur + 1'b1;
        first_pass_next = first_pass_cur && !pos_wrap;

        hdr_active   = (hdr_pos_cur != HDR_POS_FULL);
        hdr_last     = (hdr_pos_cur == HDR_POS_LAST);
        hdr_ok_next  = hdr_active ? (hdr_ok_cur && (result == hdr_byte(hdr_pos_cur)))
                                  : hdr_ok_cur;
        hdr_pos_next = hdr_active ? hdr_pos_cur + 2'd1 : hdr_pos_cur;
        match_cur    = hdr_last && hdr_ok_next;

        gen_step_next = first_pass_cur ? (state_cur * LCG_MUL) + LCG_INC : gen_step_reg;

        key_wr_en = in_fire && first_pass_cur;
        // prefetch the entry the next byte will need
        rd_addr   = in_fire ? pos_next : pos_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_step_reg <= LCG_INC;
        end
        else if (seed_we)
        begin
            seed_step_reg <= (seed_wdata * LCG_MUL) + LCG_INC;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_step_reg   <= LCG_INC;
            pos_reg        <= '0;
            first_pass_reg <= 1'b1;
            hdr_pos_reg    <= 2'd0;
            hdr_ok_reg     <= 1'b1;
        end
        else if (in_fire)
        begin
            gen_step_reg   <= gen_step_next;
            pos_reg        <= pos_next;
            first_pass_reg <= first_pass_next;
            hdr_pos_reg    <= hdr_pos_next;
            hdr_ok_reg     <= hdr_ok_next;
        end
    end

    // key store, write-first on a same-address read
    always_ff @(posedge clk)
    begin
        if (key_wr_en)
        begin
            key_mem[pos_cur] <= gen_char;
        end
        if (key_wr_en && (pos_cur == rd_addr))
            key_rd_reg <= gen_char;
        else
            key_rd_reg <= key_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_byte_reg     <= result;
            header_done_reg  <= hdr_last;
            header_match_reg <= match_cur;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign header_done  = header_done_reg;
    assign header_match = header_match_reg;

    `LCGXSC_ASSERT_NOW(a_match_needs_done, out_valid_reg && !header_done_reg, !header_match_reg, "header_match without header_done")
    `LCGXSC_ASSERT_NOW(a_pos_in_range, 1'b1, pos_reg <= PosLast, "key position past key length")
    `LCGXSC_ASSERT_NEXT(a_start_restarts, in_fire && start_of_message, hdr_pos_reg == 2'd1, "start transfer did not restart header count")
    `LCGXSC_ASSERT_NEXT(a_gen_holds, in_fire && !first_pass_cur, $stable(gen_step_reg), "generator stepped after first key pass")
    `LCGXSC_ASSERT_NEXT(a_third_byte_done, in_fire && !start_of_message && hdr_pos_reg == HDR_POS_LAST, out_valid_reg && header_done_reg, "third byte missing header_done")

endmodule
